// ----- rtl/core/ice_pkg.sv -----
// shared types, constants and codes of the isoline crossing extractor
`default_nettype none

package ice_pkg;

	localparam int MAX_COLUMNS_DEF   = 1024;
	localparam int MAX_ROWS_DEF      = 1024;
	localparam int FRACTION_BITS_DEF = 16;

	localparam int SAMPLE_W   = 16;
	localparam int SIZE_W     = 11;
	localparam int POS_W      = 26;
	localparam int NUM_W      = 20;
	localparam int KIND_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [SAMPLE_W-1:0] LEVEL_RESET = 16'd32768;
	localparam logic [SIZE_W-1:0]   SIZE_RESET  = 11'd256;

	localparam int QUEUE_DEPTH = 4;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEVEL   = 2'd0,
		REG_COLUMNS = 2'd1,
		REG_ROWS    = 2'd2
	} reg_idx_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_CORNER = 2'd0,
		KIND_HORIZ  = 2'd1,
		KIND_VERT   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		B_FETCH,
		B_DIV,
		B_PUT
	} back_state_t;

	typedef struct packed {
		kind_t               kind;
		logic [POS_W-1:0]    xbase;
		logic [POS_W-1:0]    zbase;
		logic [SAMPLE_W-1:0] num_mag;
		logic [SAMPLE_W-1:0] den_mag;
		logic [NUM_W-1:0]    point;
	} qentry_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              empty;
	} qstat_t;

endpackage

`default_nettype wire

// ----- rtl/core/ice_ram.sv -----
// generic ram, one write port and two registered read ports
`default_nettype none

module ice_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr_a,
	input  wire logic [AW-1:0]    raddr_b,
	output logic      [WIDTH-1:0] rdata_a,
	output logic      [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

`default_nettype wire

// ----- rtl/core/ice_queue.sv -----
// short queue of classified cells between front and back
`default_nettype none

module ice_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire ice_pkg::qentry_t push_entry,
	input  wire logic            pop,
	output ice_pkg::qentry_t     head,
	output ice_pkg::qstat_t      qstat
);

	import ice_pkg::*;

	qentry_t           slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QCNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	assign head        = slot_q[rd_ptr_q];
	assign qstat.count = count_q;
	assign qstat.empty = (count_q == '0);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> count_q < QCNT_W'(QUEUE_DEPTH))
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue pop while empty");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && pop |=> $stable(count_q))
		else $error("queue count moved on push and pop");

endmodule

`default_nettype wire

// ----- rtl/core/ice_front.sv -----
// front end: raster counters, line store and cell classification
`default_nettype none

module ice_front #(
	parameter int MAX_COLUMNS   = ice_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_ROWS      = ice_pkg::MAX_ROWS_DEF,
	parameter int FRACTION_BITS = ice_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [ice_pkg::SAMPLE_W-1:0]  level,
	input  wire logic [ice_pkg::SIZE_W-1:0]    cols_cfg,
	input  wire logic [ice_pkg::SIZE_W-1:0]    rows_cfg,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [ice_pkg::SAMPLE_W-1:0]  s_tdata,
	input  wire ice_pkg::qstat_t               qstat,
	output logic                               push,
	output ice_pkg::qentry_t                   push_entry
);

	import ice_pkg::*;

	localparam int COL_W = $clog2(MAX_COLUMNS);
	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int CW    = COL_W + 1;
	localparam int RW    = ROW_W + 1;

	logic [COL_W-1:0]    col_q;
	logic [ROW_W-1:0]    row_q;
	logic [NUM_W-1:0]    pts_q;
	logic [CW-1:0]       cols;
	logic [RW-1:0]       rows;
	logic [CW-1:0]       col_inc;
	logic                col_last;
	logic                row_last;
	logic                accept;
	logic [COL_W-1:0]    right_addr;
	logic [ROW_W-1:0]    zrow;

	logic                valid_s1;
	logic                test_s1;
	logic                fend_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [POS_W-1:0]    xbase_s1;
	logic [POS_W-1:0]    zbase_s1;

	logic [SAMPLE_W-1:0] c_val;
	logic [SAMPLE_W-1:0] r_val;
	logic                hit;
	kind_t               kind;
	logic [SAMPLE_W-1:0] num_mag;
	logic [SAMPLE_W-1:0] den_mag;

	function automatic logic [SAMPLE_W-1:0] abs_diff(
		input logic [SAMPLE_W-1:0] a,
		input logic [SAMPLE_W-1:0] b
	);
		return (a > b) ? a - b : b - a;
	endfunction

	function automatic logic straddles(
		input logic [SAMPLE_W-1:0] c,
		input logic [SAMPLE_W-1:0] n,
		input logic [SAMPLE_W-1:0] lvl
	);
		return ((c < lvl) && (n > lvl)) || ((c > lvl) && (n < lvl));
	endfunction

	// saturate frame size
	always_comb begin
		if (cols_cfg < SIZE_W'(2)) begin
			cols = CW'(2);
		end else if (int'(cols_cfg) > MAX_COLUMNS) begin
			cols = CW'(MAX_COLUMNS);
		end else begin
			cols = CW'(cols_cfg);
		end
		if (rows_cfg < SIZE_W'(2)) begin
			rows = RW'(2);
		end else if (int'(rows_cfg) > MAX_ROWS) begin
			rows = RW'(MAX_ROWS);
		end else begin
			rows = RW'(rows_cfg);
		end
	end

	assign s_tready   = (int'(qstat.count) + int'(valid_s1)) < QUEUE_DEPTH;
	assign accept     = s_tvalid && s_tready;
	assign col_inc    = CW'(col_q) + CW'(1);
	assign col_last   = col_inc >= cols;
	assign row_last   = (RW'(row_q) + RW'(1)) >= rows;
	assign right_addr = (col_q == COL_W'(MAX_COLUMNS - 1)) ? '0 : col_q + COL_W'(1);
	assign zrow       = row_q - ROW_W'(1);

	ice_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MAX_COLUMNS)
	) u_line_store (
		.clk     (clk),
		.we      (accept),
		.waddr   (col_q),
		.wdata   (s_tdata),
		.raddr_a (col_q),
		.raddr_b (right_addr),
		.rdata_a (c_val),
		.rdata_b (r_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			pts_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				if (col_last) begin
					col_q <= '0;
					row_q <= row_last ? '0 : row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
			if (valid_s1) begin
				pts_q <= fend_s1 ? '0 : pts_q + NUM_W'(push);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= s_tdata;
			test_s1   <= (row_q != '0) && (col_inc < cols);
			fend_s1   <= col_last && row_last;
			xbase_s1  <= POS_W'({col_q, {FRACTION_BITS{1'b0}}});
			zbase_s1  <= POS_W'({zrow, {FRACTION_BITS{1'b0}}});
		end
	end

	// classify the cell below the current sample
	always_comb begin
		hit     = 1'b1;
		kind    = KIND_CORNER;
		num_mag = '0;
		den_mag = '0;
		if (c_val == level) begin
			kind = KIND_CORNER;
		end else if (straddles(c_val, r_val, level)) begin
			kind    = KIND_HORIZ;
			num_mag = abs_diff(level, c_val);
			den_mag = abs_diff(r_val, c_val);
		end else if (straddles(c_val, sample_s1, level)) begin
			kind    = KIND_VERT;
			num_mag = abs_diff(level, c_val);
			den_mag = abs_diff(sample_s1, c_val);
		end else begin
			hit = 1'b0;
		end
	end

	assign push               = valid_s1 && test_s1 && hit;
	assign push_entry.kind    = kind;
	assign push_entry.xbase   = xbase_s1;
	assign push_entry.zbase   = zbase_s1;
	assign push_entry.num_mag = num_mag;
	assign push_entry.den_mag = den_mag;
	assign push_entry.point   = pts_q;

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> qstat.count < QCNT_W'(QUEUE_DEPTH))
		else $error("cell classified with no queue room");
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && fend_s1 |=> pts_q == '0)
		else $error("point number not cleared at frame end");
	a_crossing_den: assert property (@(posedge clk) disable iff (!arst_n)
		push && (kind != KIND_CORNER) |-> (den_mag != '0) && (num_mag < den_mag))
		else $error("crossing with fraction outside the unit range");

endmodule

`default_nettype wire

// ----- rtl/core/ice_back.sv -----
// back end: bit-serial fraction divider and output register
`default_nettype none

module ice_back #(
	parameter int FRACTION_BITS = ice_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire ice_pkg::qentry_t           head,
	input  wire ice_pkg::qstat_t            qstat,
	output logic                            pop,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	// x_position [25:0], z_position [51:26], point_number [71:52]
	output logic [71:0]                     m_tdata,
	// crossing_kind [1:0]
	output logic [ice_pkg::KIND_W-1:0]      m_tuser
);

	import ice_pkg::*;

	localparam int SW = $clog2(FRACTION_BITS);

	back_state_t              state_q;
	back_state_t              state_d;
	qentry_t                  work_q;
	logic [SAMPLE_W:0]        rem_q;
	logic [SAMPLE_W:0]        rem_sh;
	logic [FRACTION_BITS-1:0] quot_q;
	logic [SW-1:0]            step_q;
	logic                     load;
	logic                     out_free;

	logic                     out_valid_q;
	logic [POS_W-1:0]         x_q;
	logic [POS_W-1:0]         z_q;
	logic [NUM_W-1:0]         pt_q;
	kind_t                    kind_q;

	assign out_free = !out_valid_q || m_tready;
	assign rem_sh   = {rem_q[SAMPLE_W-1:0], 1'b0};

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		load    = 1'b0;
		case (state_q)
			B_FETCH: begin
				if (!qstat.empty) begin
					pop     = 1'b1;
					state_d = (head.kind == KIND_CORNER) ? B_PUT : B_DIV;
				end
			end
			B_DIV: begin
				if (step_q == '0) begin
					state_d = B_PUT;
				end
			end
			B_PUT: begin
				if (out_free) begin
					load    = 1'b1;
					state_d = B_FETCH;
				end
			end
			default: begin
				state_d = B_FETCH;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_FETCH;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			work_q <= head;
			rem_q  <= {1'b0, head.num_mag};
			quot_q <= '0;
			step_q <= SW'(FRACTION_BITS - 1);
		end else if (state_q == B_DIV) begin
			step_q <= step_q - SW'(1);
			if (rem_sh >= {1'b0, work_q.den_mag}) begin
				rem_q  <= rem_sh - {1'b0, work_q.den_mag};
				quot_q <= {quot_q[FRACTION_BITS-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				quot_q <= {quot_q[FRACTION_BITS-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_q    <= work_q.xbase + ((work_q.kind == KIND_HORIZ) ? POS_W'(quot_q) : '0);
			z_q    <= work_q.zbase + ((work_q.kind == KIND_VERT) ? POS_W'(quot_q) : '0);
			pt_q   <= work_q.point;
			kind_q <= work_q.kind;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {pt_q, z_q, x_q};
	assign m_tuser  = kind_q;

	a_div_kind: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_DIV |-> work_q.kind != KIND_CORNER)
		else $error("divider running on a corner point");
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_DIV |-> rem_q < {1'b0, work_q.den_mag})
		else $error("divider remainder out of range");
	a_load_once: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> state_q == B_FETCH && out_valid_q)
		else $error("result load did not return to fetch");

endmodule

`default_nettype wire

// ----- rtl/core/isoline_crossing_extractor.sv -----
// top level of the isoline crossing extractor
//
// channel  direction  ports                        item
// s        in         s_tvalid s_tready s_tdata    phase_sample [15:0]
// m        out        m_tvalid m_tready m_tdata    x [25:0] z [51:26] point [71:52]
//                     m_tuser                      crossing_kind [1:0]
// cfg      in         cfg_wen cfg_addr cfg_wdata   level, columns_in_use, rows_in_use
//
// front takes one sample per cycle while the 4-entry cell queue has room
// back puts a corner point straight out and a crossing after the one-bit-per-cycle
// divider; cells without a point cost the back nothing
// the line store is not cleared; reset returns counters, queue and output to empty
// sustained: 1 sample per cycle with sparse points, m_tready high; else divider rate
`default_nettype none

module isoline_crossing_extractor #(
	parameter int MAX_COLUMNS   = ice_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_ROWS      = ice_pkg::MAX_ROWS_DEF,
	parameter int FRACTION_BITS = ice_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wen,
	input  wire logic [ice_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  wire logic [ice_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// phase_sample [15:0]
	input  wire logic [15:0]                    s_tdata,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// x_position [25:0], z_position [51:26], point_number [71:52]
	output logic [71:0]                         m_tdata,
	// crossing_kind [1:0]
	output logic [ice_pkg::KIND_W-1:0]          m_tuser
);

	import ice_pkg::*;

	logic [SAMPLE_W-1:0] level_q;
	logic [SIZE_W-1:0]   cols_q;
	logic [SIZE_W-1:0]   rows_q;

	logic                push;
	qentry_t             push_entry;
	logic                pop;
	qentry_t             head;
	qstat_t              qstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= LEVEL_RESET;
			cols_q  <= SIZE_RESET;
			rows_q  <= SIZE_RESET;
		end else if (cfg_wen) begin
			case (cfg_addr)
				REG_LEVEL:   level_q <= cfg_wdata;
				REG_COLUMNS: cols_q  <= cfg_wdata[SIZE_W-1:0];
				REG_ROWS:    rows_q  <= cfg_wdata[SIZE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	ice_front #(
		.MAX_COLUMNS   (MAX_COLUMNS),
		.MAX_ROWS      (MAX_ROWS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.level      (level_q),
		.cols_cfg   (cols_q),
		.rows_cfg   (rows_q),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.qstat      (qstat),
		.push       (push),
		.push_entry (push_entry)
	);

	ice_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	ice_back #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.qstat    (qstat),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

// ----- bench/crossing_checker.sv -----
// checker that predicts isoline points from accepted samples and compares each result item
`timescale 1ns / 1ps

module crossing_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [ice_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [ice_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [15:0]                    s_tdata,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [71:0]                    m_tdata,
	input  logic [ice_pkg::KIND_W-1:0]     m_tuser,
	output int                             mismatches,
	output int                             points_checked,
	output int                             points_pending
);
	import ice_pkg::*;

	typedef struct packed {
		logic [POS_W-1:0] x_pos;
		logic [POS_W-1:0] z_pos;
		kind_t            kind;
		logic [NUM_W-1:0] number;
	} point_t;

	point_t              expected_points [$];
	logic [SAMPLE_W-1:0] line_buf [MAX_COLUMNS_DEF];
	logic [SAMPLE_W-1:0] level;
	logic [SIZE_W-1:0]   columns;
	logic [SIZE_W-1:0]   rows;
	logic [NUM_W-1:0]    found;
	int                  col_at;
	int                  row_at;

	function automatic int fit_size(input logic [SIZE_W-1:0] v, input int hi);
		if (v < 2)
			return 2;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic logic straddles(input logic [15:0] c, input logic [15:0] n,
			input logic [15:0] lvl);
		return (c < lvl && n > lvl) || (c > lvl && n < lvl);
	endfunction

	function automatic logic [31:0] crossing_fraction(input logic [15:0] c,
			input logic [15:0] n, input logic [15:0] lvl);
		logic [31:0] num;
		logic [31:0] den;
		num = (lvl > c) ? lvl - c : c - lvl;
		num = num << FRACTION_BITS_DEF;
		den = (n > c) ? n - c : c - n;
		return (den != 0) ? num / den : 32'd0;
	endfunction

	task automatic predict_sample(input logic [SAMPLE_W-1:0] sample);
		int                  cols;
		int                  rws;
		logic [SAMPLE_W-1:0] c;
		logic [SAMPLE_W-1:0] right;
		logic [31:0]         t;
		logic                hit;
		point_t              p;
		cols = fit_size(columns, MAX_COLUMNS_DEF);
		rws = fit_size(rows, MAX_ROWS_DEF);
		if (row_at >= 1 && col_at + 1 < cols && col_at + 1 < MAX_COLUMNS_DEF) begin
			c = line_buf[col_at];
			right = line_buf[col_at + 1];
			p.x_pos = col_at[POS_W-1:0] << FRACTION_BITS_DEF;
			p.z_pos = POS_W'((row_at - 1) << FRACTION_BITS_DEF);
			p.kind = KIND_CORNER;
			hit = 1'b1;
			if (c == level) begin
				p.kind = KIND_CORNER;
			end else if (straddles(c, right, level)) begin
				p.kind = KIND_HORIZ;
				t = crossing_fraction(c, right, level);
				p.x_pos = p.x_pos + t[POS_W-1:0];
			end else if (straddles(c, sample, level)) begin
				p.kind = KIND_VERT;
				t = crossing_fraction(c, sample, level);
				p.z_pos = p.z_pos + t[POS_W-1:0];
			end else begin
				hit = 1'b0;
			end
			if (hit) begin
				p.number = found;
				found = found + 1'b1;
				expected_points.push_back(p);
			end
		end
		if (col_at < MAX_COLUMNS_DEF)
			line_buf[col_at] = sample;
		if (col_at + 1 >= cols) begin
			col_at = 0;
			if (row_at + 1 >= rws) begin
				row_at = 0;
				found = '0;
			end else begin
				row_at = row_at + 1;
			end
		end else begin
			col_at = col_at + 1;
		end
	endtask

	task automatic report_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		$display("%0t: %s expected %0d got %0d", $time, field, want, got);
		mismatches++;
	endtask

	task automatic check_point(input point_t got);
		point_t want;
		if (expected_points.size() == 0) begin
			$display("%0t: point expected none got x %0d z %0d kind %0d number %0d",
				$time, got.x_pos, got.z_pos, got.kind, got.number);
			mismatches++;
			return;
		end
		want = expected_points.pop_front();
		if (got.x_pos !== want.x_pos)
			report_field("x_position", want.x_pos, got.x_pos);
		if (got.z_pos !== want.z_pos)
			report_field("z_position", want.z_pos, got.z_pos);
		if (got.kind !== want.kind)
			report_field("crossing_kind", want.kind, got.kind);
		if (got.number !== want.number)
			report_field("point_number", want.number, got.number);
	endtask

	always @(posedge clk or negedge arst_n) begin
		point_t got;
		if (!arst_n) begin
			expected_points.delete();
			level = LEVEL_RESET;
			columns = SIZE_RESET;
			rows = SIZE_RESET;
			col_at = 0;
			row_at = 0;
			found = '0;
			mismatches = 0;
			points_checked = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.x_pos = m_tdata[POS_W-1:0];
				got.z_pos = m_tdata[2*POS_W-1:POS_W];
				got.number = m_tdata[2*POS_W+NUM_W-1:2*POS_W];
				got.kind = kind_t'(m_tuser);
				check_point(got);
				points_checked++;
			end
			if (s_tvalid && s_tready)
				predict_sample(s_tdata);
			if (cfg_wen) begin
				case (reg_idx_t'(cfg_addr))
					REG_LEVEL:   level = cfg_wdata;
					REG_COLUMNS: columns = cfg_wdata[SIZE_W-1:0];
					REG_ROWS:    rows = cfg_wdata[SIZE_W-1:0];
					default: ;
				endcase
			end
		end
		points_pending = expected_points.size();
	end

endmodule

// ----- bench/tb_top.sv -----
// bench top for the isoline crossing extractor: clock, reset, stimulus frames and verdict
`timescale 1ns / 1ps

module tb_top;
	import ice_pkg::*;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 100;
	localparam int RANDOM_ITEMS  = 700;
	localparam int HOLD_CYCLES   = 400;

	typedef enum int {
		FILL_RANDOM,
		FILL_NEAR,
		FILL_CHECKER,
		FILL_MIXED
	} fill_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_addr = REG_LEVEL;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_tvalid = 1'b0;
	logic [15:0]           s_tdata = '0;
	logic                  m_tready = 1'b0;
	logic                  s_tready;
	logic                  m_tvalid;
	logic [71:0]           m_tdata;
	logic [KIND_W-1:0]     m_tuser;

	int mismatches;
	int points_checked;
	int points_pending;

	int cycle_count = 0;
	int tx_idle_pct = 12;
	int rx_idle_pct = 48;
	int hold_left = 0;
	int samples_sent = 0;
	int frames_sent = 0;
	int cur_level = 32768;
	int eff_cols = 256;
	int eff_rows = 256;

	isoline_crossing_extractor DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	crossing_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.mismatches    (mismatches),
		.points_checked(points_checked),
		.points_pending(points_pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver: long hold-off when requested, else random stalls
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	function automatic int fit_size(input logic [SIZE_W-1:0] v, input int hi);
		if (v < 2)
			return 2;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic logic [15:0] fill_value(input fill_t f, input int x, input int z);
		int v;
		case (f)
			FILL_CHECKER: v = ((x + z) % 2) ? 65535 : 0;
			FILL_NEAR:    v = cur_level + int'($urandom_range(6)) - 3;
			FILL_MIXED: begin
				case ($urandom_range(4))
					0: v = cur_level;
					1: v = 0;
					2: v = 65535;
					3: v = cur_level + int'($urandom_range(40)) - 20;
					default: v = $urandom_range(65535);
				endcase
			end
			default: v = $urandom_range(65535);
		endcase
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return v[15:0];
	endfunction

	task automatic configure(input logic [15:0] lvl, input logic [15:0] cols,
			input logic [15:0] rws);
		cfg_wen <= 1'b1;
		cfg_addr <= REG_LEVEL;
		cfg_wdata <= lvl;
		@(posedge clk);
		cfg_addr <= REG_COLUMNS;
		cfg_wdata <= cols;
		@(posedge clk);
		cfg_addr <= REG_ROWS;
		cfg_wdata <= rws;
		@(posedge clk);
		cfg_wen <= 1'b0;
		cur_level = lvl;
		eff_cols = fit_size(cols[SIZE_W-1:0], MAX_COLUMNS_DEF);
		eff_rows = fit_size(rws[SIZE_W-1:0], MAX_ROWS_DEF);
	endtask

	task automatic send_sample(input logic [15:0] v);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= v;
		do @(posedge clk); while (!s_tready);
		samples_sent++;
	endtask

	task automatic send_frame(input fill_t f);
		for (int z = 0; z < eff_rows; z++)
			for (int x = 0; x < eff_cols; x++)
				send_sample(fill_value(f, x, z));
		frames_sent++;
	endtask

	// wait until every predicted point is out and the block has gone quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (points_pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [15:0] corner_frame [9];
		logic [15:0] lvl;
		logic [15:0] cols;
		logic [15:0] rws;
		int          small_sent;
		int          frame_no;
		corner_frame = '{16'h8000, 16'h0000, 16'hFFFF,
		                 16'hFFFF, 16'h8000, 16'h0000,
		                 16'h0000, 16'hFFFF, 16'h8000};
		small_sent = 0;
		frame_no = 0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner, horizontal and vertical points at the sample extremes
		configure(16'h8000, 16'd3, 16'd3);
		foreach (corner_frame[i])
			send_sample(corner_frame[i]);
		frames_sent++;
		settle();

		// level at zero, sizes below the minimum
		configure(16'h0000, 16'd0, 16'd1);
		send_sample(16'h0000);
		send_sample(16'hFFFF);
		send_sample(16'h0001);
		send_sample(16'h0000);
		frames_sent++;
		settle();

		// level at full scale, frame cut short by shrinking both sizes mid-frame
		configure(16'hFFFF, 16'd4, 16'd4);
		for (int i = 0; i < 10; i++)
			send_sample(fill_value(FILL_MIXED, i % 4, i / 4));
		settle();
		configure(16'hFFFF, 16'd2, 16'd2);
		send_sample(fill_value(FILL_MIXED, 2, 2));
		frames_sent++;
		settle();

		// output held off while a dense frame streams in
		configure(16'h8000, 16'd8, 16'd6);
		hold_left = HOLD_CYCLES;
		send_frame(FILL_CHECKER);
		small_sent += eff_cols * eff_rows;
		settle();

		while (small_sent < RANDOM_ITEMS) begin
			if (small_sent < RANDOM_ITEMS / 3) begin
				tx_idle_pct = 12;
				rx_idle_pct = 48;
			end else if (small_sent < 2 * RANDOM_ITEMS / 3) begin
				tx_idle_pct = 48;
				rx_idle_pct = 12;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			case ($urandom_range(7))
				0: lvl = 16'h0000;
				1: lvl = 16'hFFFF;
				2: lvl = 16'h0001;
				3: lvl = 16'hFFFE;
				default: lvl = 16'($urandom_range(65535));
			endcase
			case ($urandom_range(9))
				0: cols = 16'd0;
				1: cols = 16'd1;
				2: cols = 16'd2;
				default: cols = 16'($urandom_range(12, 3));
			endcase
			case ($urandom_range(9))
				0: rws = 16'd0;
				1: rws = 16'd1;
				default: rws = 16'($urandom_range(8, 2));
			endcase
			if (frame_no == 4) begin
				// oversized width clamped, row then cut short by a narrower width
				configure(lvl, 16'd2047, 16'd0);
				for (int i = 0; i < 6; i++)
					send_sample(fill_value(FILL_MIXED, i, 0));
				settle();
				configure(lvl, 16'd2, 16'd0);
				for (int i = 0; i < 3; i++)
					send_sample(fill_value(FILL_MIXED, i, 1));
				frames_sent++;
				small_sent += 9;
			end else if (frame_no == 12) begin
				// oversized height clamped, frame then cut short by fewer rows
				configure(lvl, 16'd1, 16'd2047);
				for (int i = 0; i < 8; i++)
					send_sample(fill_value(FILL_MIXED, i % 2, i / 2));
				settle();
				configure(lvl, 16'd1, 16'd0);
				for (int i = 0; i < 2; i++)
					send_sample(fill_value(FILL_MIXED, i, 4));
				frames_sent++;
				small_sent += 10;
			end else begin
				configure(lvl, cols, rws);
				send_frame(fill_t'($urandom_range(3)));
				small_sent += eff_cols * eff_rows;
			end
			settle();
			frame_no++;
		end

		$display("covered %0d samples in %0d frames, sizes from 2x2 up, oversized and cut short",
			samples_sent, frames_sent);
		$display("compared %0d points, %0d field mismatches", points_checked, mismatches);
		if (mismatches == 0 && points_pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
